### src/lcd_mode_line_timer_macros.svh
// Assertion macros shared by the LCD mode and line timer checker.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef LCD_MODE_LINE_TIMER_MACROS_SVH
`define LCD_MODE_LINE_TIMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcd timer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LMLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcd timer check failed");

`endif

### src/lcdt_pkg.sv
// Package for the LCD mode and line timer: mode codes, timing constants and shared types.
// Used by lcdt_step, lcd_mode_line_timer and lcdt_checker; depends on nothing.
package lcdt_pkg;

  localparam int DotW  = 10;
  localparam int LineW = 8;
  localparam int ElapW = 8;
  localparam int CfgW  = 8;
  localparam int SieW  = 4;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_VRAM   = 2'd3;

  localparam logic [1:0] CFG_LCD_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_LINE_COMPARE    = 2'd1;
  localparam logic [1:0] CFG_STAT_INT_ENABLE = 2'd2;

  localparam logic [DotW-1:0] DOTS_OAM      = 10'd80;
  localparam logic [DotW-1:0] DOTS_VRAM     = 10'd172;
  localparam logic [DotW-1:0] DOTS_HBLANK   = 10'd204;
  localparam logic [DotW-1:0] DOTS_LINE     = 10'd456;
  localparam logic [DotW-1:0] PENDING_DELAY = 10'd4;
  localparam logic [DotW-1:0] DOT_MAX       = 10'd1023;

  localparam logic [LineW-1:0] LAST_LINE   = 8'd153;
  localparam logic [LineW-1:0] VBLANK_LINE = 8'd144;

  // Interrupt select bits of stat_int_enable.
  localparam int SelHblank = 0;
  localparam int SelVblank = 1;
  localparam int SelOam    = 2;
  localparam int SelCoin   = 3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [LineW-1:0] line;
    logic [DotW-1:0]  dot;
    logic             pending;
    logic             coin;
  } lcdt_state_t;

  typedef struct packed {
    logic stat_raise;
    logic stat_clear;
    logic vblank_raise;
    logic render;
    logic frame;
  } lcdt_events_t;

endpackage

### src/lcdt_step.sv
// Next-state and event logic for one tick of the LCD mode and line timer.
// Purely combinational; depends on lcdt_pkg.
module lcdt_step import lcdt_pkg::*; (
  input  lcdt_state_t       st,
  input  logic              lcd_enable,
  input  logic [LineW-1:0]  line_compare,
  input  logic [SieW-1:0]   stat_int_enable,
  input  logic [ElapW-1:0]  elapsed_cycles,
  output lcdt_state_t       st_nxt,
  output lcdt_events_t      ev
);

  logic [DotW:0]   sum;
  logic [DotW-1:0] dot_sat;
  logic            fire;

  assign sum     = {1'b0, st.dot} + {{(DotW + 1 - ElapW){1'b0}}, elapsed_cycles};
  assign dot_sat = sum[DotW] ? DOT_MAX : sum[DotW-1:0];
  assign fire    = st.pending && (dot_sat > PENDING_DELAY);

  always_comb begin
    st_nxt = st;
    ev     = '0;
    if (lcd_enable) begin
      st_nxt.dot = dot_sat;
      unique case (st.mode)
        MODE_OAM: begin
          if (fire) begin
            ev.stat_raise  = 1'b1;
            st_nxt.pending = 1'b0;
          end
          if (dot_sat >= DOTS_OAM) begin
            st_nxt.dot    = dot_sat - DOTS_OAM;
            st_nxt.mode   = MODE_VRAM;
            ev.stat_clear = 1'b1;
          end
        end
        MODE_VRAM: begin
          if (dot_sat >= DOTS_VRAM) begin
            st_nxt.dot  = dot_sat - DOTS_VRAM;
            st_nxt.mode = MODE_HBLANK;
            ev.render   = 1'b1;
            if (stat_int_enable[SelHblank]) st_nxt.pending = 1'b1;
          end
        end
        MODE_HBLANK: begin
          if (fire) begin
            ev.stat_raise  = 1'b1;
            st_nxt.pending = 1'b0;
          end
          if (dot_sat >= DOTS_HBLANK) begin
            st_nxt.dot  = dot_sat - DOTS_HBLANK;
            st_nxt.line = st.line + LineW'(1);
            st_nxt.coin = (st_nxt.line == line_compare);
            if (st_nxt.coin && stat_int_enable[SelCoin]) st_nxt.pending = 1'b1;
            if (st_nxt.line == VBLANK_LINE) begin
              ev.vblank_raise = 1'b1;
              st_nxt.mode     = MODE_VBLANK;
              if (stat_int_enable[SelVblank]) st_nxt.pending = 1'b1;
            end else begin
              st_nxt.mode = MODE_OAM;
              if (stat_int_enable[SelOam]) st_nxt.pending = 1'b1;
            end
          end
        end
        MODE_VBLANK: begin
          if (fire) begin
            ev.stat_raise  = 1'b1;
            st_nxt.pending = 1'b0;
          end
          if (dot_sat >= DOTS_LINE) begin
            st_nxt.dot  = dot_sat - DOTS_LINE;
            st_nxt.line = st.line + LineW'(1);
            st_nxt.coin = (st_nxt.line == line_compare);
            if (st_nxt.coin && stat_int_enable[SelCoin]) ev.stat_raise = 1'b1;
            if (st_nxt.line > LAST_LINE) begin
              // Frame wrap: compare line zero too, that match only goes pending.
              ev.frame    = 1'b1;
              st_nxt.mode = MODE_OAM;
              st_nxt.line = '0;
              st_nxt.coin = (line_compare == '0);
              if (st_nxt.coin && stat_int_enable[SelCoin]) st_nxt.pending = 1'b1;
              if (stat_int_enable[SelOam]) ev.stat_raise = 1'b1;
            end
          end
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end
  end

endmodule

### src/lcd_mode_line_timer.sv
// LCD mode and line timer: one tick beat in, one status beat out, through the input register,
// then the state update into the result register; throughput one beat per cycle while the
// result channel is not stalled, with the next-state logic in lcdt_step and the two-deep buffering.
// Synchronous active-low reset clears the configuration, the mode/line/dot state and
// both valid flags; payload registers are not reset.
module lcd_mode_line_timer import lcdt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CfgW-1:0]   cfg_wdata,
  // tick input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ElapW-1:0]  in_elapsed_cycles,
  // status result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_lcd_mode,
  output logic [LineW-1:0]  out_current_line,
  output logic              out_coincidence,
  output logic              out_stat_irq_raise,
  output logic              out_stat_irq_clear,
  output logic              out_vblank_irq_raise,
  output logic              out_render_line,
  output logic              out_frame_done
);

  // Configuration registers.
  logic             lcd_enable_r;
  logic [LineW-1:0] line_compare_r;
  logic [SieW-1:0]  stat_int_enable_r;

  // Timer state, advanced once per beat leaving the input register.
  lcdt_state_t st_r, st_nxt;
  lcdt_events_t ev;

  // Input register.
  logic             in_valid_r;
  logic [ElapW-1:0] elapsed_r;

  // Result register.
  logic             out_valid_r;
  logic [1:0]       mode_out_r;
  logic [LineW-1:0] line_out_r;
  logic             coin_out_r;
  lcdt_events_t     ev_out_r;

  logic advance;

  // A beat moves from the input register to the result register whenever the result
  // register is empty or is being drained in this same cycle.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_enable_r      <= 1'b0;
      line_compare_r    <= '0;
      stat_int_enable_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LCD_ENABLE:      lcd_enable_r      <= cfg_wdata[0];
        CFG_LINE_COMPARE:    line_compare_r    <= cfg_wdata[LineW-1:0];
        CFG_STAT_INT_ENABLE: stat_int_enable_r <= cfg_wdata[SieW-1:0];
        default: ;
      endcase
    end
  end

  lcdt_step u_step (
    .st              (st_r),
    .lcd_enable      (lcd_enable_r),
    .line_compare    (line_compare_r),
    .stat_int_enable (stat_int_enable_r),
    .elapsed_cycles  (elapsed_r),
    .st_nxt          (st_nxt),
    .ev              (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{mode: MODE_HBLANK, line: '0, dot: '0, pending: 1'b0, coin: 1'b0};
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers load alongside their valid flags.
  always_ff @(posedge clk) begin
    if (!in_stall) elapsed_r <= in_elapsed_cycles;
    if (advance) begin
      mode_out_r <= st_nxt.mode;
      line_out_r <= st_nxt.line;
      coin_out_r <= st_nxt.coin;
      ev_out_r   <= ev;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_lcd_mode         = mode_out_r;
  assign out_current_line     = line_out_r;
  assign out_coincidence      = coin_out_r;
  assign out_stat_irq_raise   = ev_out_r.stat_raise;
  assign out_stat_irq_clear   = ev_out_r.stat_clear;
  assign out_vblank_irq_raise = ev_out_r.vblank_raise;
  assign out_render_line      = ev_out_r.render;
  assign out_frame_done       = ev_out_r.frame;

endmodule

### src/lcdt_checker.sv
// Port-level checker for the LCD mode and line timer, bound to the top level.
// Depends on lcdt_pkg and the assertion macros header.
`include "lcd_mode_line_timer_macros.svh"

module lcdt_checker import lcdt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       out_lcd_mode,
  input logic [LineW-1:0] out_current_line,
  input logic             out_stat_irq_clear,
  input logic             out_vblank_irq_raise,
  input logic             out_render_line,
  input logic             out_frame_done
);

  // A stalled result beat stays offered.
  `LMLT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // A render pulse only comes with the step into horizontal blanking.
  `LMLT_ASSERT_NOW(a_render_mode, clk, rst_n, out_valid && out_render_line, out_lcd_mode == MODE_HBLANK)

  // A frame wrap always lands on line zero in OAM search.
  `LMLT_ASSERT_NOW(a_frame_wrap, clk, rst_n, out_valid && out_frame_done, (out_current_line == '0) && (out_lcd_mode == MODE_OAM))

  // The vblank interrupt fires exactly on entry at the first blanking line.
  `LMLT_ASSERT_NOW(a_vblank_entry, clk, rst_n, out_valid && out_vblank_irq_raise, (out_current_line == VBLANK_LINE) && (out_lcd_mode == MODE_VBLANK))

  // The stat clear comes with VRAM entry.
  `LMLT_ASSERT_NOW(a_clear_vram, clk, rst_n, out_valid && out_stat_irq_clear, out_lcd_mode == MODE_VRAM)

endmodule

bind lcd_mode_line_timer lcdt_checker u_lcdt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_lcd_mode         (out_lcd_mode),
  .out_current_line     (out_current_line),
  .out_stat_irq_clear   (out_stat_irq_clear),
  .out_vblank_irq_raise (out_vblank_irq_raise),
  .out_render_line      (out_render_line),
  .out_frame_done       (out_frame_done)
);
